### rtl/bsp_pkg.sv
// Shared types and constants for the bitmap shape plotter.
package bsp_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int ROW_W      = 64;
  localparam int ADDR_W     = 6;

  localparam logic [1:0] CMD_SQUARE   = 2'd0;
  localparam logic [1:0] CMD_LINE     = 2'd1;
  localparam logic [1:0] CMD_TRIANGLE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Latched request, with coordinates sign-extended to 9 bits.
  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [8:0] xa;
    logic signed [8:0] ya;
    logic signed [8:0] xb;
    logic signed [8:0] yb;
    logic [6:0]        len;
    logic              right;
    logic              down;
  } req_t;

  // Clamp a 7-bit register to 1..max.
  function automatic logic [6:0] eff_dim(input logic [6:0] v);
    logic [6:0] d;
    d = v;
    if (d == 7'd0) d = 7'd1;
    if (d > 7'd64) d = 7'd64;
    return d;
  endfunction

endpackage

### rtl/bitmap_shape_plotter.sv
// Top level of the bitmap shape plotter: control, canvas RAM and row output.
//
// Usage: a command request on the input channel (valid/stall) draws one shape
// into a 64x64 one-bit canvas held in a RAM. The bounds check runs first; a
// failing command gives one result with out_of_range=1, last_row=1, loaded
// from S_BAD once the output register may load, and the plotter returns to idle.
// A passing command sweeps rows 0..63 once, read-modify-write through the RAM
// port (one row per cycle, behind the registered read), waits in S_READ until
// the first row is read out, then emits rows 0..h-1, one per cycle when the
// receiver does not stall, last_row on row h-1. The single canvas RAM serves
// both the draw and readout sweeps.
// The input channel stalls while a command is in progress; a new command is
// taken once the last result is loaded into the output register. The output
// register holds its request while out stall is high, and readout pauses.
// Reset clears all 64 canvas rows in a clearing pass (no command taken) and
// sets width and height to 64. Configuration writes are always ready.
module bitmap_shape_plotter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic signed [7:0] x_a,
  input  logic signed [7:0] y_a,
  input  logic signed [7:0] x_b,
  input  logic signed [7:0] y_b,
  input  logic [6:0]  side_length,
  input  logic        face_right,
  input  logic        face_down,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_of_range,
  output logic [5:0]  row_number,
  output logic [63:0] row_pixels,
  output logic        last_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import bsp_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DRAW, S_READ, S_BAD} state_t;

  state_t      state;
  req_t        req;
  logic [6:0]  cw, ch, w, h;
  logic [6:0]  rd_cnt;   // read address counter
  logic [6:0]  wr_cnt;   // write/emit counter, lags one
  logic        rd_live;
  logic        ram_we;
  logic [5:0]  ram_waddr, ram_raddr;
  logic [63:0] ram_wdata, ram_rdata, add_mask, wmask;
  logic        bad;
  logic signed [8:0] sxa, sya, sxb, syb, slen, sw, sh;

  assign cfg_ready = 1'b1;
  assign w = eff_dim(cw);
  assign h = eff_dim(ch);
  assign in_stall = (state != S_IDLE);

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cw <= 7'd64;
      ch <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WIDTH) cw <= cfg_data;
      else ch <= cfg_data;
    end
  end

  // Bounds check on the incoming request.
  always_comb begin
    sxa = {x_a[7], x_a};
    sya = {y_a[7], y_a};
    sxb = {x_b[7], x_b};
    syb = {y_b[7], y_b};
    slen = {2'd0, side_length};
    sw = {2'd0, w};
    sh = {2'd0, h};
    case (command)
      CMD_SQUARE: bad = sxa < 0 || sya < 0 || sxa + slen > sw || sya + slen > sh;
      CMD_LINE: bad = sxa < 0 || sxa >= sw || sya < 0 || sya >= sh ||
                      sxb < 0 || sxb >= sw || syb < 0 || syb >= sh;
      CMD_TRIANGLE: bad = sxa < 0 || sya < 0 ||
                          (face_right ? (sxa + slen > sw) : (sxa - slen < -9'sd1)) ||
                          (face_down ? (sya + slen > sh) : (sya - slen < -9'sd1));
      default: bad = 1'b1;
    endcase
  end

  bsp_row_mask u_mask (
    .req (req), .w (w), .h (h), .row (wr_cnt[5:0]), .mask (add_mask)
  );

  for (genvar gi = 0; gi < 64; gi++) begin : g_wm
    assign wmask[gi] = (7'(gi) < w);
  end

  // Output register may load when empty or being taken.
  logic out_load, emit_bad, emit_row;
  assign out_load = !out_valid || !out_stall;
  assign emit_bad = (state == S_BAD) && out_load;
  assign emit_row = (state == S_READ) && rd_live && out_load;

  // RAM access.
  always_comb begin
    ram_raddr = rd_cnt[5:0];
    ram_waddr = wr_cnt[5:0];
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | add_mask;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = rd_cnt[5:0];
        ram_wdata = '0;
      end
      S_DRAW: ram_we = rd_live;
      // hold the current row until it is emitted
      S_READ: if (!emit_row) ram_raddr = wr_cnt[5:0];
      default: ;
    endcase
  end

  bsp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_HEIGHT)) u_canvas (
    .clk (clk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
    .raddr (ram_raddr), .rdata (ram_rdata)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_cnt  <= '0;
      wr_cnt  <= '0;
      rd_live <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_bad || emit_row || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + 7'd1;
          if (rd_cnt == 7'd63) begin
            state <= S_IDLE;
            rd_cnt <= '0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req.cmd <= command;
            req.xa <= sxa; req.ya <= sya; req.xb <= sxb; req.yb <= syb;
            req.len <= side_length;
            req.right <= face_right; req.down <= face_down;
            rd_cnt <= '0;
            rd_live <= 1'b0;
            state <= bad ? S_BAD : S_DRAW;
          end
        end
        S_BAD: begin
          if (emit_bad) begin
            out_of_range <= 1'b1;
            row_number <= '0;
            row_pixels <= '0;
            last_row <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DRAW: begin
          wr_cnt <= rd_cnt;
          rd_live <= (rd_cnt < 7'd64);
          rd_cnt <= rd_cnt + 7'd1;
          if (rd_cnt == 7'd64) begin
            state <= S_READ;
            rd_cnt <= 7'd1;
            wr_cnt <= '0;
            rd_live <= 1'b0;
          end
        end
        S_READ: begin
          // rd_live marks that ram_rdata holds row wr_cnt.
          if (!rd_live) begin
            rd_live <= 1'b1;
          end else if (emit_row) begin
            out_of_range <= 1'b0;
            row_number <= wr_cnt[5:0];
            row_pixels <= ram_rdata & wmask;
            last_row <= (wr_cnt == h - 7'd1);
            wr_cnt <= wr_cnt + 7'd1;
            rd_cnt <= rd_cnt + 7'd1;
            if (wr_cnt == h - 7'd1) begin
              state <= S_IDLE;
              rd_live <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drawn rows fall inside the height in use.
  a_row_in_h: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> ({1'b0, row_number} < h))
    else $error("row beyond height");
  // A rejected command ends at once.
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> last_row)
    else $error("range fault not last");
  // No request accepted while a command is being worked.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW || state == S_READ) |-> in_stall)
    else $error("accept while busy");
  // Stored rows beyond width never leave.
  a_wmask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((row_pixels & ~wmask) == 64'd0))
    else $error("pixel beyond width");
endmodule

### rtl/bsp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module bsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/bsp_row_mask.sv
// Computes the pixel mask one shape adds to a given row.
module bsp_row_mask (
  input  bsp_pkg::req_t      req,
  input  logic [6:0]         w,
  input  logic [6:0]         h,
  input  logic [5:0]         row,
  output logic [63:0]        mask
);
  import bsp_pkg::*;

  logic signed [9:0] r, lo, hi, dx, dy, adx, xc;
  logic signed [9:0] xa, ya, xb, yb, ln;
  logic signed [9:0] k;
  logic [63:0]       wmask;
  logic              hit;

  // Span [lo,hi] of columns in this row, then clip to height and width.
  always_comb begin
    xa  = 10'(req.xa);
    ya  = 10'(req.ya);
    xb  = 10'(req.xb);
    yb  = 10'(req.yb);
    ln  = $signed({3'd0, req.len});
    r   = {4'd0, row};
    lo  = 10'sd0;
    hi  = -10'sd1;
    dx  = xb - xa;
    dy  = yb - ya;
    adx = dx < 0 ? -dx : dx;
    k   = 10'sd0;
    xc  = 10'sd0;
    hit = 1'b0;
    case (req.cmd)
      CMD_SQUARE: begin
        if (r >= ya && r < ya + ln) begin
          lo = xa;
          hi = xa + ln - 10'sd1;
        end
      end
      CMD_LINE: begin
        if (xa == xb) begin
          if ((r >= ya && r <= yb) || (r >= yb && r <= ya)) begin
            lo = xa;
            hi = xa;
          end
        end else if (ya == yb) begin
          if (r == ya) begin
            lo = xa < xb ? xa : xb;
            hi = xa < xb ? xb : xa;
          end
        end else begin
          k = (dy > 0) ? r - ya : ya - r;
          hit = (k >= 0) && (k <= adx);
          xc = (dx > 0) ? xa + k : xa - k;
          if (hit) begin
            lo = xc;
            hi = xc;
          end
        end
      end
      CMD_TRIANGLE: begin
        k = req.down ? r - ya : ya - r;
        if (k >= 0 && k < ln) begin
          if (req.right) begin
            lo = xa;
            hi = xa + ln - k - 10'sd1;
          end else begin
            lo = xa - ln + k + 10'sd1;
            hi = xa;
          end
        end
      end
      default: ;
    endcase
    if (r >= $signed({3'd0, h})) hi = -10'sd1;
    if (hi >= $signed({3'd0, w})) hi = $signed({3'd0, w}) - 10'sd1;
    if (lo < 0) lo = 10'sd0;
  end

  // Column range mask: set the bits from lo to hi.
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      wmask[i] = ($signed(10'(i)) >= lo) && ($signed(10'(i)) <= hi);
    end
    mask = wmask;
  end
endmodule
